// ----- hw/rtl/cqr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_pkg
// Types and constants shared by the circular queue controller, datapath,
// top level and checker.
// ----------------------------------------------------------------------------
package cqr_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OUSER_W = STAT_W + 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_REV  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OSEL_ZERO  = 2'd0,
    OSEL_NEG1  = 2'd1,
    OSEL_RDATA = 2'd2
  } outsel_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_POP_RD  = 3'd1,
    S_SWAP_RD = 3'd2,
    S_SWAP_WA = 3'd3,
    S_SWAP_WB = 3'd4
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    do_push;
    logic    pop_commit;
    logic    rd_en;
    logic    rd_swap;
    logic    rev_load;
    logic    wr_a;
    logic    wr_b_step;
    logic    out_load;
    outsel_e out_sel;
    status_e out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic at_most_one;
    logic swap_last;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cqr_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_ctrl
// Sequencer for the circular queue: decodes each word, steps the datapath
// through pop reads and the swap sequence of a reverse.
// ----------------------------------------------------------------------------
module cqr_ctrl import cqr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [FUNC_W-1:0] func_i,
  input  wire sts_t              sts_i,
  output cmd_t                   cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_sel    = OSEL_ZERO;
    cmd_o.out_status = ST_DONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (func_i)
            OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.out_status = ST_FULL;
              end else begin
                cmd_o.do_push = 1'b1;
              end
            end
            OP_POP: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
                cmd_o.out_sel    = OSEL_NEG1;
              end else begin
                cmd_o.rd_en = 1'b1;
                state_d     = S_POP_RD;
              end
            end
            OP_REV: begin
              if (sts_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else if (sts_i.at_most_one) begin
                cmd_o.out_load = 1'b1;
              end else begin
                cmd_o.rev_load = 1'b1;
                state_d        = S_SWAP_RD;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
            end
          endcase
        end
      end
      S_POP_RD: begin
        cmd_o.pop_commit = 1'b1;
        cmd_o.out_load   = 1'b1;
        cmd_o.out_sel    = OSEL_RDATA;
        state_d          = S_IDLE;
      end
      S_SWAP_RD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_swap = 1'b1;
        state_d       = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        cmd_o.wr_a = 1'b1;
        state_d    = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        cmd_o.wr_b_step = 1'b1;
        if (sts_i.swap_last) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end else begin
          state_d = S_SWAP_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/cqr_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_dp
// Datapath of the circular queue: entry memory, head and tail pointers,
// occupancy, swap pointers for reverse, and the result register.
// ----------------------------------------------------------------------------
module cqr_dp import cqr_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  input  wire logic signed [DATA_W-1:0] push_value_i,
  input  wire logic                     out_ready_i,
  output logic                          out_valid_o,
  output logic signed [DATA_W-1:0]      pop_value_o,
  output logic [STAT_W-1:0]             status_o,
  output logic                          now_empty_o,
  output logic                          now_full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SWP_W = CNT_W - 1;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem_q [DEPTH];

  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0] pa_q, pa_d, pb_q, pb_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SWP_W-1:0] swp_q, swp_d;
  logic [DATA_W-1:0] rda_q, rdb_q;
  logic [PTR_W-1:0] rd_addr_a, wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              wr_en;

  logic                     out_vld_q, out_vld_d;
  logic signed [DATA_W-1:0] out_val_q, out_val_d;
  logic [STAT_W-1:0]        out_st_q;
  logic                     out_emp_q, out_ful_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  // Pointer and count updates.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    swp_d  = swp_q;
    if (cmd_i.do_push) begin
      tail_d = ptr_inc(tail_q);
      cnt_d  = cnt_q + 1'b1;
    end else if (cmd_i.pop_commit) begin
      head_d = ptr_inc(head_q);
      cnt_d  = cnt_q - 1'b1;
    end
    if (cmd_i.rev_load) begin
      pa_d  = head_q;
      pb_d  = ptr_dec(tail_q);
      swp_d = cnt_q[CNT_W-1:1];
    end else if (cmd_i.wr_b_step) begin
      pa_d  = ptr_inc(pa_q);
      pb_d  = ptr_dec(pb_q);
      swp_d = swp_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      pa_q   <= '0;
      pb_q   <= '0;
      swp_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      swp_q  <= swp_d;
    end
  end

  // One write port shared by push and the two halves of a swap.
  assign rd_addr_a = cmd_i.rd_swap ? pa_q : head_q;
  assign wr_en     = cmd_i.do_push | cmd_i.wr_a | cmd_i.wr_b_step;
  always_comb begin
    if (cmd_i.do_push) begin
      wr_addr = tail_q;
      wr_data = push_value_i;
    end else if (cmd_i.wr_a) begin
      wr_addr = pa_q;
      wr_data = rdb_q;
    end else begin
      wr_addr = pb_q;
      wr_data = rda_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rda_q <= mem_q[rd_addr_a];
      rdb_q <= mem_q[pb_q];
    end
  end

  // Result register.
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_comb begin
    out_vld_d = out_vld_q && !out_ready_i;
    if (cmd_i.out_load) begin
      out_vld_d = 1'b1;
    end
    case (cmd_i.out_sel)
      OSEL_NEG1:  out_val_d = '1;
      OSEL_RDATA: out_val_d = rda_q;
      default:    out_val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q <= out_val_d;
      out_st_q  <= cmd_i.out_status;
      out_emp_q <= (cnt_d == '0);
      out_ful_q <= (cnt_d == CNT_W'(DEPTH));
    end
  end

  assign sts_o.empty       = (cnt_q == '0);
  assign sts_o.full        = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.at_most_one = (cnt_q <= CNT_W'(1));
  assign sts_o.swap_last   = (swp_q == SWP_W'(1));

  assign out_valid_o = out_vld_q;
  assign pop_value_o = out_val_q;
  assign status_o    = out_st_q;
  assign now_empty_o = out_emp_q;
  assign now_full_o  = out_ful_q;

endmodule
`default_nettype wire

// ----- hw/rtl/circular_queue_with_reverse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circular_queue_with_reverse
// Circular FIFO of signed 32-bit words with push, pop and in-place reverse.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata               tuser
// s_axis   in   push_value[31:0]    func[1:0]
// m_axis   out  pop_value[31:0]     status[1:0], now_empty[2], now_full[3]
//
// Push and every refused or no-op word finish in the cycle they are accepted.
// Pop passes through a read state, since the entry memory has a registered read port.
// Reverse of n entries makes floor(n/2) swaps: each swap is one
// dual-address read followed by two writes through the single write port.
// One word is worked at a time; a new word is taken once the result register
// is empty or being drained. Reset clears pointers and occupancy at once;
// entry contents are undefined until written.
// ----------------------------------------------------------------------------
module circular_queue_with_reverse import cqr_pkg::*; #(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [DATA_W-1:0]  s_axis_tdata,  // push_value
  input  wire logic [FUNC_W-1:0]  s_axis_tuser,  // func
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [DATA_W-1:0]       m_axis_tdata,  // pop_value
  output logic [OUSER_W-1:0]      m_axis_tuser   // status, now_empty, now_full
);

  cmd_t                     cmd;
  sts_t                     sts;
  logic signed [DATA_W-1:0] pop_value;
  logic [STAT_W-1:0]        status;
  logic                     now_empty, now_full;

  cqr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cqr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .push_value_i (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pop_value_o  (pop_value),
    .status_o     (status),
    .now_empty_o  (now_empty),
    .now_full_o   (now_full)
  );

  assign m_axis_tdata = pop_value;
  assign m_axis_tuser = {now_full, now_empty, status};

endmodule
`default_nettype wire

// ----- hw/rtl/cqr_chk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cqr_chk
// Port-level checker for the circular queue, bound to the top level.
// ----------------------------------------------------------------------------
module cqr_chk import cqr_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic [DATA_W-1:0]  s_axis_tdata,
  input wire logic [FUNC_W-1:0]  s_axis_tuser,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [DATA_W-1:0]  m_axis_tdata,
  input wire logic [OUSER_W-1:0] m_axis_tuser
);

  // An offered input word holds until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
      && $stable(s_axis_tuser))
    else $error("input word changed while waiting");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // No new word is taken while a result is stuck at the output.
  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // A refused push leaves the queue full.
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[STAT_W-1:0] == ST_FULL) |-> m_axis_tuser[STAT_W+1])
    else $error("full status without full flag");

  // An empty refusal leaves the queue empty and never full.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[STAT_W-1:0] == ST_EMPTY)
      |-> m_axis_tuser[STAT_W] && !m_axis_tuser[STAT_W+1])
    else $error("empty status without empty flag");

endmodule

bind circular_queue_with_reverse cqr_chk u_cqr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/sv/circular_queue_with_reverse_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_queue_with_reverse_tb
// Streams push, pop, reverse and spare-code words into the circular queue and
// checks every result word against a cycle-free mirror of the queue contents.
// Runs a directed opening, then random fill, drain and blended traffic under
// several sender and receiver idling mixes, including one long receiver
// hold-off that backs the block up.
// ----------------------------------------------------------------------------
module circular_queue_with_reverse_tb;
  import cqr_pkg::*;

  localparam int unsigned DEPTH = 128;
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int RUN_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  // Longest reverse of a full queue plus some margin.
  localparam int TAIL_CYCLES = 3 * (DEPTH / 2) + 16;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] value;
  } cmd_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_e           status;
    logic              now_empty;
    logic              now_full;
  } result_t;

  typedef enum logic [1:0] {
    TR_FILL  = 2'd0,
    TR_DRAIN = 2'd1,
    TR_BLEND = 2'd2
  } traffic_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DATA_W-1:0]   s_axis_tdata = '0;   // push_value
  logic [FUNC_W-1:0]   s_axis_tuser = '0;   // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;        // pop_value
  logic [OUSER_W-1:0]  m_axis_tuser;        // status[1:0], now_empty, now_full

  // Mirror of the queue, updated once per accepted input word.
  logic [DATA_W-1:0]          mirror_mem [DEPTH];
  int unsigned                mirror_head = 0;
  int unsigned                mirror_tail = 0;
  int unsigned                mirror_count = 0;

  cmd_word_t word_backlog [$];
  result_t   due_results [$];

  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  logic        rx_hold = 1'b0;
  int          fail_cnt = 0;
  int          cycle_cnt = 0;

  // Stimulus generator state; the first random segment is a push-heavy fill segment.
  int unsigned gen_count = 0;
  traffic_e    seg_mode = TR_FILL;
  int          seg_left = DEPTH + DEPTH / 4 + 8;

  circular_queue_with_reverse #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned slot_at(input int unsigned offset);
    return (mirror_head + offset) % DEPTH;
  endfunction

  function automatic void apply_queue_op(input logic [FUNC_W-1:0] func,
                                         input logic [DATA_W-1:0] value);
    result_t     res;
    int unsigned n;
    int unsigned a;
    int unsigned b;
    logic [DATA_W-1:0] tmp;
    res.pop_value = '0;
    res.status = ST_DONE;
    if (func == OP_PUSH) begin
      if (mirror_count >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        mirror_mem[mirror_tail] = value;
        mirror_tail = (mirror_tail + 1) % DEPTH;
        mirror_count++;
      end
    end else if (func == OP_POP) begin
      if (mirror_count == 0) begin
        res.status = ST_EMPTY;
        res.pop_value = '1;
      end else begin
        res.pop_value = mirror_mem[mirror_head];
        mirror_head = (mirror_head + 1) % DEPTH;
        mirror_count--;
      end
    end else if (func == OP_REV) begin
      if (mirror_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        n = mirror_count;
        for (int unsigned i = 0; i < n / 2; i++) begin
          a = slot_at(i);
          b = slot_at(n - 1 - i);
          tmp = mirror_mem[a];
          mirror_mem[a] = mirror_mem[b];
          mirror_mem[b] = tmp;
        end
      end
    end
    res.now_empty = (mirror_count == 0);
    res.now_full = (mirror_count >= DEPTH);
    due_results.push_back(res);
  endfunction

  task automatic add_word(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value);
    cmd_word_t w;
    w.func = func;
    w.value = value;
    word_backlog.push_back(w);
    if (func == OP_PUSH && gen_count < DEPTH) gen_count++;
    if (func == OP_POP && gen_count > 0) gen_count--;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_random_word();
    int                roll;
    logic [FUNC_W-1:0] func;
    if (seg_left <= 0) begin
      seg_mode = traffic_e'($urandom_range(2, 0));
      case (seg_mode)
        TR_FILL:  seg_left = (DEPTH - gen_count) * 5 / 4 + $urandom_range(12, 4);
        TR_DRAIN: seg_left = gen_count * 5 / 4 + $urandom_range(12, 4);
        default:  seg_left = $urandom_range(50, 10);
      endcase
    end
    seg_left--;
    roll = $urandom_range(99, 0);
    case (seg_mode)
      TR_FILL: begin
        func = (roll < 90) ? OP_PUSH : (roll < 94) ? OP_POP : (roll < 98) ? OP_REV : FUNC_SPARE;
      end
      TR_DRAIN: begin
        func = (roll < 90) ? OP_POP : (roll < 94) ? OP_PUSH : (roll < 98) ? OP_REV : FUNC_SPARE;
      end
      default: begin
        func = (roll < 40) ? OP_PUSH : (roll < 80) ? OP_POP : (roll < 96) ? OP_REV : FUNC_SPARE;
      end
    endcase
    add_word(func, pick_value());
  endtask

  task automatic wait_drained();
    while (word_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input int src_pct, input int snk_pct, input int n_words,
                           input bit long_hold);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (n_words) add_random_word();
    if (long_hold) begin
      // The sender keeps offering words while the result side is blocked.
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
    wait_drained();
  endtask

  // Input side: offers the backlog, with random gaps between words.
  always @(posedge clk_i or negedge rst_ni) begin : drive_s
    cmd_word_t next_w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_queue_op(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_backlog.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          next_w = word_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_w.value;
          s_axis_tuser <= next_w.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_m
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: pop_value %0d, tuser %b",
               $signed(m_axis_tdata), m_axis_tuser);
        fail_cnt++;
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata !== want.pop_value) begin
          $error("pop_value: expected %0d, got %0d",
                 $signed(want.pop_value), $signed(m_axis_tdata));
          fail_cnt++;
        end
        if (m_axis_tuser[STAT_W-1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser[STAT_W-1:0]);
          fail_cnt++;
        end
        if (m_axis_tuser[STAT_W] !== want.now_empty) begin
          $error("now_empty: expected %0b, got %0b", want.now_empty, m_axis_tuser[STAT_W]);
          fail_cnt++;
        end
        if (m_axis_tuser[STAT_W+1] !== want.now_full) begin
          $error("now_full: expected %0b, got %0b", want.now_full, m_axis_tuser[STAT_W+1]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue corner cases, then small odd reverses.
    add_word(OP_POP, 32'h1234_5678);
    add_word(OP_REV, '1);
    add_word(FUNC_SPARE, '1);
    add_word(OP_PUSH, 32'h7FFF_FFFF);
    add_word(OP_REV, 32'h0);
    add_word(OP_PUSH, 32'h8000_0000);
    add_word(OP_PUSH, 32'h0);
    add_word(OP_REV, 32'hDEAD_BEEF);
    add_word(OP_POP, '0);
    add_word(OP_PUSH, '1);
    add_word(OP_PUSH, 32'h5555_5555);
    add_word(OP_PUSH, 32'hAAAA_AAAA);
    add_word(OP_REV, '0);
    repeat (5) add_word(OP_POP, '1);
    add_word(OP_REV, '0);
    add_word(FUNC_SPARE, '0);
    wait_drained();

    run_phase(0, 0, 150, 1'b1);
    run_phase(86, 0, 130, 1'b0);
    run_phase(0, 86, 130, 1'b0);
    run_phase(18, 18, 140, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && due_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
